>>> rtl/bsc_pkg.sv
package bsc_pkg;

    localparam int DIV_W = 64;

    localparam logic [2:0] REG_TEMP_CALIB       = 3'd0;
    localparam logic [2:0] REG_PRESS_CALIB_LOW  = 3'd1;
    localparam logic [2:0] REG_PRESS_CALIB_HIGH = 3'd2;
    localparam logic [2:0] REG_PRESS_CALIB_LAST = 3'd3;
    localparam logic [2:0] REG_HUM_CALIB        = 3'd4;
    localparam logic [2:0] REG_HUMIDITY_ENABLED = 3'd5;

    localparam logic [1:0] TP_OK       = 2'd0;
    localparam logic [1:0] TP_SKIPPED  = 2'd1;
    localparam logic [1:0] TP_DIV_ZERO = 2'd2;
    localparam logic [1:0] TP_NEGATIVE = 2'd3;

    localparam logic [1:0] HUM_OK       = 2'd0;
    localparam logic [1:0] HUM_DISABLED = 2'd1;
    localparam logic [1:0] HUM_SKIPPED  = 2'd2;

    localparam logic [19:0] SKIP20 = 20'h80000;
    localparam logic [15:0] SKIP16 = 16'h8000;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } sample_t;

    typedef struct packed {
        logic signed [23:0] temperature_centi;
        logic [31:0]        pressure_pa;
        logic [16:0]        humidity_pct;
        logic [1:0]         tp_status;
        logic [1:0]         hum_status;
    } result_t;

    typedef struct packed {
        logic [23:0] tc;
        logic        tp_skip;
        logic [16:0] hum;
        logic [1:0]  hum_st;
        logic        dz;
        logic        neg;
    } div_tag_t;

    function automatic logic [31:0] asr32(logic [31:0] x, int unsigned s);
        return 32'($signed(x) >>> s);
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int unsigned s);
        return 64'($signed(x) >>> s);
    endfunction

endpackage

>>> rtl/bsc_div.sv
module bsc_div
    import bsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [DIV_W-1:0]   num,
    input  logic [DIV_W-1:0]   den,
    input  div_tag_t           tag_in,
    output logic               out_vld,
    output logic [DIV_W-1:0]   quo,
    output div_tag_t           tag_out
);

    localparam int W = DIV_W;

    logic [W-1:0] rem_reg [0:W];
    logic [W-1:0] nq_reg  [0:W];
    logic [W-1:0] den_reg [0:W];
    div_tag_t     tag_reg [0:W];
    logic [W:0]   vld_reg;

    logic [W-1:0] rem_next [1:W];
    logic [W-1:0] nq_next  [1:W];
    logic [W:0]   trial    [1:W];

    // one quotient bit per stage, restoring
    always_comb
    begin
        for (int k = 1; k <= W; k++)
        begin
            trial[k] = {rem_reg[k-1], nq_reg[k-1][W-1]};
            if (trial[k] >= {1'b0, den_reg[k-1]})
            begin
                rem_next[k] = W'(trial[k] - {1'b0, den_reg[k-1]});
                nq_next[k]  = {nq_reg[k-1][W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[k][W-1:0];
                nq_next[k]  = {nq_reg[k-1][W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[W-1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= num;
            den_reg[0] <= den;
            tag_reg[0] <= tag_in;
            for (int k = 1; k <= W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                den_reg[k] <= den_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_vld = vld_reg[W];
    assign quo     = nq_reg[W];
    assign tag_out = tag_reg[W];

endmodule

>>> rtl/barometric_sensor_compensation.sv
// compensation of raw temperature / pressure / humidity readings
// sample channel: sample_valid, sample_stall, sample carries one raw set
// result channel: result_valid, result_stall, result carries the compensated
// values with tp_status and hum_status
// a transaction completes at a rising edge with valid high and stall low
// most pipeline stages belong to the 64-bit signed division, one quotient bit
// per pipeline stage
// throughput: one transaction per cycle on each channel when it is not stalled
// calibration must be written via cfg_we / cfg_index / cfg_data only while
// no transaction is in flight, which the block does not enforce; unknown
// indexes are ignored; reset clears all calibration registers, humidity
// disabled, and empties the pipeline; result_valid is low after reset
// while the receiver stalls, the result register holds; the pipeline keeps
// advancing into empty slots and sample_stall rises only once the last
// stage holds a result with nowhere to go
module barometric_sensor_compensation
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [47:0] temp_calib_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_last_reg;
    logic [63:0] hum_calib_reg;
    logic        hum_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_last_reg <= '0;
            hum_calib_reg  <= '0;
            hum_en_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEMP_CALIB:       temp_calib_reg <= cfg_data[47:0];
                REG_PRESS_CALIB_LOW:  press_low_reg  <= cfg_data;
                REG_PRESS_CALIB_HIGH: press_high_reg <= cfg_data;
                REG_PRESS_CALIB_LAST: press_last_reg <= cfg_data[15:0];
                REG_HUM_CALIB:        hum_calib_reg  <= cfg_data;
                REG_HUMIDITY_ENABLED: hum_en_reg     <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // calibration coefficients
    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    assign t1 = 32'(temp_calib_reg[15:0]);
    assign t2 = 32'($signed(temp_calib_reg[31:16]));
    assign t3 = 32'($signed(temp_calib_reg[47:32]));
    assign p1 = 64'(press_low_reg[15:0]);
    assign p2 = 64'($signed(press_low_reg[31:16]));
    assign p3 = 64'($signed(press_low_reg[47:32]));
    assign p4 = 64'($signed(press_low_reg[63:48]));
    assign p5 = 64'($signed(press_high_reg[15:0]));
    assign p6 = 64'($signed(press_high_reg[31:16]));
    assign p7 = 64'($signed(press_high_reg[47:32]));
    assign p8 = 64'($signed(press_high_reg[63:48]));
    assign p9 = 64'($signed(press_last_reg));
    assign h1 = 32'(hum_calib_reg[7:0]);
    assign h2 = 32'($signed(hum_calib_reg[23:8]));
    assign h3 = 32'(hum_calib_reg[31:24]);
    assign h4 = 32'($signed(hum_calib_reg[43:32]));
    assign h5 = 32'($signed(hum_calib_reg[55:44]));
    assign h6 = 32'($signed(hum_calib_reg[63:56]));

    logic en;
    logic [10:1] vld_reg;
    logic [6:1]  pv_reg;

    div_tag_t         div_tag_in, div_tag_out;
    logic             div_vld;
    logic [DIV_W-1:0] div_quo;

    assign en           = !pv_reg[6] || !result_valid || !result_stall;
    assign sample_stall = !en;

    // front stages
    sample_t     in_reg;
    logic        skip_reg [2:10];
    logic [1:0]  hst_reg  [2:10];
    logic [23:0] tc_reg   [5:10];
    logic [19:0] rp_reg   [2:7];
    logic [15:0] rh_reg   [2:4];

    logic [31:0] m1_reg, dsq_reg;
    logic [31:0] v1_reg, m2_reg;
    logic [31:0] tf_reg;
    logic [63:0] asq_reg, ap5_reg, ap2_reg;
    logic [63:0] b1_reg, b3_reg, ap5b_reg, ap2b_reg;
    logic [63:0] b_reg, a2_reg;
    logic [63:0] a3_reg, pn_reg;
    logic [63:0] a4_reg, num_reg;
    logic [63:0] ma_reg, mb_reg;
    logic        neg_reg, dz_reg;
    logic [31:0] vh6_reg, vh3_reg, xnum_reg;
    logic [31:0] prod_reg, x6_reg;
    logic [31:0] yh2_reg, x7_reg;
    logic [31:0] xy8_reg;
    logic [31:0] ss_reg, xy9_reg;
    logic [31:0] t10_reg, xy10_reg;

    logic [31:0] rt32, dd, tfa, hv_in, hv, hv_clamp;
    logic [63:0] pa;
    logic signed [32:0] pa_s;

    assign rt32  = 32'(in_reg.raw_temperature);
    assign dd    = (rt32 >> 4) - t1;
    assign pa    = 64'($signed(tf_reg)) - 64'd128000;
    // fine temperature less 128000 always fits 33 signed bits
    assign pa_s  = $signed(pa[32:0]);
    assign tfa   = tf_reg - 32'd76800;
    assign hv_in = xy10_reg - asr32(t10_reg, 4);

    always_comb
    begin
        hv = hv_in;
        if (hv[31])
        begin
            hv_clamp = '0;
        end
        else if (hv > 32'd419430400)
        begin
            hv_clamp = 32'd419430400;
        end
        else
        begin
            hv_clamp = hv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            pv_reg  <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[9:1], sample_valid};
            pv_reg  <= {pv_reg[5:1], div_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg <= sample;

            // stage 2
            skip_reg[2] <= (in_reg.raw_temperature == SKIP20)
                        || (in_reg.raw_pressure == SKIP20);
            if (!hum_en_reg)
            begin
                hst_reg[2] <= HUM_DISABLED;
            end
            else if ((in_reg.raw_temperature == SKIP20)
                     || (in_reg.raw_humidity == SKIP16))
            begin
                hst_reg[2] <= HUM_SKIPPED;
            end
            else
            begin
                hst_reg[2] <= HUM_OK;
            end
            rp_reg[2] <= in_reg.raw_pressure;
            rh_reg[2] <= in_reg.raw_humidity;
            m1_reg    <= ((rt32 >> 3) - (t1 << 1)) * t2;
            dsq_reg   <= dd * dd;

            for (int k = 3; k <= 10; k++)
            begin
                skip_reg[k] <= skip_reg[k-1];
                hst_reg[k]  <= hst_reg[k-1];
            end
            for (int k = 3; k <= 7; k++)
            begin
                rp_reg[k] <= rp_reg[k-1];
            end
            for (int k = 3; k <= 4; k++)
            begin
                rh_reg[k] <= rh_reg[k-1];
            end
            for (int k = 6; k <= 10; k++)
            begin
                tc_reg[k] <= tc_reg[k-1];
            end

            // stage 3, 4: fine temperature
            v1_reg <= asr32(m1_reg, 11);
            m2_reg <= asr32(dsq_reg, 12) * t3;
            tf_reg <= v1_reg + asr32(m2_reg, 14);

            // stage 5
            tc_reg[5] <= 24'(asr32(tf_reg * 32'd5 + 32'd128, 8));
            asq_reg   <= 64'(pa_s * pa_s);
            ap5_reg   <= pa * p5;
            ap2_reg   <= pa * p2;
            vh6_reg   <= tfa * h6;
            vh3_reg   <= tfa * h3;
            xnum_reg  <= (32'(rh_reg[4]) << 14) - (h4 << 20) - h5 * tfa + 32'd16384;

            // stage 6
            b1_reg   <= asq_reg * p6;
            b3_reg   <= asq_reg * p3;
            ap5b_reg <= ap5_reg;
            ap2b_reg <= ap2_reg;
            prod_reg <= asr32(vh6_reg, 10) * (asr32(vh3_reg, 11) + 32'd32768);
            x6_reg   <= asr32(xnum_reg, 15);

            // stage 7
            b_reg   <= b1_reg + (ap5b_reg << 17) + (p4 << 35);
            a2_reg  <= asr64(b3_reg, 8) + (ap2b_reg << 12);
            yh2_reg <= (asr32(prod_reg, 10) + 32'd2097152) * h2;
            x7_reg  <= x6_reg;

            // stage 8
            a3_reg  <= (64'h0000_8000_0000_0000 + a2_reg) * p1;
            pn_reg  <= ((64'd1048576 - 64'(rp_reg[7])) << 31) - b_reg;
            xy8_reg <= x7_reg * asr32(yh2_reg + 32'd8192, 14);

            // stage 9
            a4_reg  <= asr64(a3_reg, 33);
            num_reg <= pn_reg * 64'd3125;
            ss_reg  <= asr32(xy8_reg, 15) * asr32(xy8_reg, 15);
            xy9_reg <= xy8_reg;

            // stage 10: operand magnitudes
            ma_reg   <= num_reg[63] ? (64'd0 - num_reg) : num_reg;
            mb_reg   <= a4_reg[63] ? (64'd0 - a4_reg) : a4_reg;
            neg_reg  <= num_reg[63] ^ a4_reg[63];
            dz_reg   <= (a4_reg == 64'd0);
            t10_reg  <= asr32(ss_reg, 7) * h1;
            xy10_reg <= xy9_reg;
        end
    end

    always_comb
    begin
        div_tag_in.tc      = skip_reg[10] ? 24'd0 : tc_reg[10];
        div_tag_in.tp_skip = skip_reg[10];
        div_tag_in.hum     = (hst_reg[10] == HUM_OK) ? 17'(hv_clamp >> 12) : 17'd0;
        div_tag_in.hum_st  = hst_reg[10];
        div_tag_in.dz      = dz_reg;
        div_tag_in.neg     = neg_reg;
    end

    bsc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld_reg[10]),
        .num     (ma_reg),
        .den     (mb_reg),
        .tag_in  (div_tag_in),
        .out_vld (div_vld),
        .quo     (div_quo),
        .tag_out (div_tag_out)
    );

    // back stages
    div_tag_t    ptag_reg [1:6];
    logic [63:0] q_reg    [1:5];
    logic [63:0] ll_reg, bp8_reg, hh_reg, bq_reg, b4_reg, ah_reg, sm_reg, pf_reg;
    logic [31:0] lh_reg;
    logic [63:0] hq;

    assign hq = asr64(q_reg[1], 13);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ptag_reg[1] <= div_tag_out;
            for (int k = 2; k <= 6; k++)
            begin
                ptag_reg[k] <= ptag_reg[k-1];
            end
            for (int k = 2; k <= 5; k++)
            begin
                q_reg[k] <= q_reg[k-1];
            end
            q_reg[1] <= div_tag_out.neg ? (64'd0 - div_quo) : div_quo;

            ll_reg  <= 64'(hq[31:0]) * 64'(hq[31:0]);
            lh_reg  <= hq[31:0] * hq[63:32];
            bp8_reg <= q_reg[1] * p8;

            hh_reg <= ll_reg + {lh_reg[30:0], 33'd0};
            bq_reg <= asr64(bp8_reg, 19);

            ah_reg <= hh_reg * p9;
            b4_reg <= bq_reg;

            sm_reg <= q_reg[4] + asr64(ah_reg, 25) + b4_reg;

            pf_reg <= asr64(sm_reg, 8) + (p7 << 4);
        end
    end

    result_t res_next;

    always_comb
    begin
        res_next.temperature_centi = $signed(ptag_reg[6].tc);
        res_next.humidity_pct      = ptag_reg[6].hum;
        res_next.hum_status        = ptag_reg[6].hum_st;
        res_next.pressure_pa       = '0;
        if (ptag_reg[6].tp_skip)
        begin
            res_next.tp_status = TP_SKIPPED;
        end
        else if (ptag_reg[6].dz)
        begin
            res_next.tp_status = TP_DIV_ZERO;
        end
        else if (pf_reg[63])
        begin
            res_next.tp_status = TP_NEGATIVE;
        end
        else
        begin
            res_next.tp_status = TP_OK;
            res_next.pressure_pa = (pf_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                             : pf_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else if (!result_valid || !result_stall)
        begin
            result_valid <= pv_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid || !result_stall)
        begin
            result <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg[6] && result_valid && result_stall |=> pv_reg[6])
        else $error("last stage lost while result blocked");

    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.tp_status == TP_SKIPPED
        |-> result.temperature_centi == 24'sd0 && result.pressure_pa == 32'd0)
        else $error("skipped reading with non-zero values");

    a_hum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.hum_status != HUM_OK |-> result.humidity_pct == 17'd0)
        else $error("humidity non-zero with bad status");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.humidity_pct <= 17'd102400)
        else $error("humidity above full scale");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bsc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    barometric_sensor_compensation dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int LATENCY = 81;
    localparam longint CYCLE_LIMIT = 400000;

    // indexes past the last register
    localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

    logic [47:0] temp_coeffs;
    logic [63:0] press_coeffs_lo;
    logic [63:0] press_coeffs_hi;
    logic [15:0] press_coeff_p9;
    logic [63:0] hum_coeffs;
    logic        hum_present;

    result_t     pending_results[$];
    int          error_count = 0;
    longint      cycle_count = 0;
    int          send_idle_pct;
    int          recv_idle_pct;

    typedef struct {
        sample_t raw;
        logic    known;
        result_t want;
    } vector_t;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] sx64(logic [63:0] v, int w);
        logic [63:0] m;
        m = 64'd1 << (w - 1);
        return ((v & ((m << 1) - 64'd1)) ^ m) - m;
    endfunction

    function automatic logic [31:0] sra32(logic [31:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [63:0] sra64(logic [63:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    function automatic result_t compensate(sample_t s);
        result_t r;
        logic [31:0] rt, rp, rh, t1, t2, t3, v1, dd, v2, tf, tc;
        logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, sq;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, num, ma, mb, q;
        logic        t_skip;
        r = '0;
        rt = {12'd0, s.raw_temperature};
        rp = {12'd0, s.raw_pressure};
        rh = {16'd0, s.raw_humidity};
        t1 = {16'd0, temp_coeffs[15:0]};
        t2 = 32'(sx64(64'(temp_coeffs[31:16]), 16));
        t3 = 32'(sx64(64'(temp_coeffs[47:32]), 16));
        v1 = sra32(((rt >> 3) - t1 * 32'd2) * t2, 11);
        dd = (rt >> 4) - t1;
        v2 = sra32(sra32(dd * dd, 12) * t3, 14);
        tf = v1 + v2;
        tc = sra32(tf * 32'd5 + 32'd128, 8);
        t_skip = (s.raw_temperature == SKIP20);
        if (t_skip || s.raw_pressure == SKIP20)
        begin
            r.tp_status = TP_SKIPPED;
        end
        else
        begin
            p1 = {48'd0, press_coeffs_lo[15:0]};
            p2 = sx64(64'(press_coeffs_lo[31:16]), 16);
            p3 = sx64(64'(press_coeffs_lo[47:32]), 16);
            p4 = sx64(64'(press_coeffs_lo[63:48]), 16);
            p5 = sx64(64'(press_coeffs_hi[15:0]), 16);
            p6 = sx64(64'(press_coeffs_hi[31:16]), 16);
            p7 = sx64(64'(press_coeffs_hi[47:32]), 16);
            p8 = sx64(64'(press_coeffs_hi[63:48]), 16);
            p9 = sx64(64'(press_coeff_p9), 16);
            r.temperature_centi = tc[23:0];
            a = sx64(64'(tf), 32) - 64'd128000;
            b = a * a * p6;
            b += a * p5 * 64'd131072;
            b += p4 * 64'd34359738368;
            a = sra64(a * a * p3, 8) + a * p2 * 64'd4096;
            a = sra64((64'd140737488355328 + a) * p1, 33);
            if (a == 64'd0)
            begin
                r.tp_status = TP_DIV_ZERO;
            end
            else
            begin
                p = 64'd1048576 - 64'(rp);
                num = (p * 64'd2147483648 - b) * 64'd3125;
                ma = num[63] ? -num : num;
                mb = a[63] ? -a : a;
                q = ma / mb;
                p = (num[63] != a[63]) ? -q : q;
                a = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
                b = sra64(p8 * p, 19);
                p = sra64(p + a + b, 8) + p7 * 64'd16;
                if (p[63])
                    r.tp_status = TP_NEGATIVE;
                else
                begin
                    r.tp_status = TP_OK;
                    r.pressure_pa = (p > 64'hFFFFFFFF) ? 32'hFFFFFFFF : p[31:0];
                end
            end
        end
        if (!hum_present)
            r.hum_status = HUM_DISABLED;
        else if (t_skip || s.raw_humidity == SKIP16)
            r.hum_status = HUM_SKIPPED;
        else
        begin
            h1 = {24'd0, hum_coeffs[7:0]};
            h2 = 32'(sx64(64'(hum_coeffs[23:8]), 16));
            h3 = {24'd0, hum_coeffs[31:24]};
            h4 = 32'(sx64(64'(hum_coeffs[43:32]), 12));
            h5 = 32'(sx64(64'(hum_coeffs[55:44]), 12));
            h6 = 32'(sx64(64'(hum_coeffs[63:56]), 8));
            v = tf - 32'd76800;
            x = sra32(rh * 32'd16384 - h4 * 32'd1048576 - h5 * v + 32'd16384, 15);
            y = sra32(sra32(v * h6, 10) * (sra32(v * h3, 11) + 32'd32768), 10)
                + 32'd2097152;
            y = sra32(y * h2 + 32'd8192, 14);
            v = x * y;
            sq = sra32(v, 15);
            v -= sra32(sra32(sq * sq, 7) * h1, 4);
            if (v[31])
                v = 32'd0;
            else if (v > 32'd419430400)
                v = 32'd419430400;
            r.humidity_pct = v[28:12];
            r.hum_status = HUM_OK;
        end
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TEMP_CALIB:       temp_coeffs = val[47:0];
            REG_PRESS_CALIB_LOW:  press_coeffs_lo = val;
            REG_PRESS_CALIB_HIGH: press_coeffs_hi = val;
            REG_PRESS_CALIB_LAST: press_coeff_p9 = val[15:0];
            REG_HUM_CALIB:        hum_coeffs = val;
            REG_HUMIDITY_ENABLED: hum_present = val[0];
            default: ;
        endcase
    endtask

    task automatic drain;
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // typical factory calibration
    task automatic load_typical;
        write_reg(REG_TEMP_CALIB, 64'({16'sd50, 16'sd26435, 16'd27504}));
        write_reg(REG_PRESS_CALIB_LOW, {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477});
        write_reg(REG_PRESS_CALIB_HIGH, {-16'sd12000, 16'sd15500, -16'sd7, 16'sd140});
        write_reg(REG_PRESS_CALIB_LAST, 64'd6000);
        write_reg(REG_HUM_CALIB, {8'sd30, 12'sd50, 12'sd312, 8'd0, 16'sd366, 8'd75});
        write_reg(REG_HUMIDITY_ENABLED, 64'd1);
    endtask

    // called at a rising edge, returns just after the accepting edge
    task automatic send_item(sample_t s, result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        pending_results.push_back(want);
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    task automatic send(sample_t s);
        send_item(s, compensate(s));
    endtask

    function automatic sample_t rand_sample();
        sample_t s;
        int k;
        k = $urandom_range(19);
        s.raw_temperature = (k == 0) ? SKIP20 :
            (k < 4) ? 20'($urandom) : 20'($urandom_range(600000, 380000));
        k = $urandom_range(19);
        s.raw_pressure = (k == 0) ? SKIP20 :
            (k < 4) ? 20'($urandom) : 20'($urandom_range(450000, 200000));
        k = $urandom_range(19);
        s.raw_humidity = (k == 0) ? SKIP16 : 16'($urandom);
        return s;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.temperature_centi !== want.temperature_centi)
                begin
                    $error("temperature_centi expected %0h actual %0h",
                           want.temperature_centi, result.temperature_centi);
                    error_count++;
                end
                if (result.pressure_pa !== want.pressure_pa)
                begin
                    $error("pressure_pa expected %0h actual %0h",
                           want.pressure_pa, result.pressure_pa);
                    error_count++;
                end
                if (result.humidity_pct !== want.humidity_pct)
                begin
                    $error("humidity_pct expected %0h actual %0h",
                           want.humidity_pct, result.humidity_pct);
                    error_count++;
                end
                if (result.tp_status !== want.tp_status)
                begin
                    $error("tp_status expected %0d actual %0d",
                           want.tp_status, result.tp_status);
                    error_count++;
                end
                if (result.hum_status !== want.hum_status)
                begin
                    $error("hum_status expected %0d actual %0d",
                           want.hum_status, result.hum_status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        vector_t vectors[$];
        vector_t vec;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 14;
        recv_idle_pct = 70;
        temp_coeffs = '0;
        press_coeffs_lo = '0;
        press_coeffs_hi = '0;
        press_coeff_p9 = '0;
        hum_coeffs = '0;
        hum_present = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // after reset all calibration is zero: divisor zero, humidity off
        vectors.push_back('{'{20'd0, 20'd0, 16'd0}, 1'b1,
                            '{24'd0, 32'd0, 17'd0, TP_DIV_ZERO, HUM_DISABLED}});
        vectors.push_back('{'{SKIP20, 20'd5, 16'd5}, 1'b1,
                            '{24'd0, 32'd0, 17'd0, TP_SKIPPED, HUM_DISABLED}});
        vectors.push_back('{'{20'd7, SKIP20, 16'hFFFF}, 1'b1,
                            '{24'd0, 32'd0, 17'd0, TP_SKIPPED, HUM_DISABLED}});
        vectors.push_back('{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b1,
                            '{24'd0, 32'd0, 17'd0, TP_DIV_ZERO, HUM_DISABLED}});
        foreach (vectors[i])
        begin
            vec = vectors[i];
            if (vec.known)
                send_item(vec.raw, vec.want);
            else
                send(vec.raw);
        end
        drain();

        load_typical();
        vectors.delete();
        vectors.push_back('{'{20'd519888, 20'd415148, 16'd30000}, 1'b0, '0});
        vectors.push_back('{'{20'd0, 20'd0, 16'd0}, 1'b0, '0});
        vectors.push_back('{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b0, '0});
        vectors.push_back('{'{20'hFFFFF, 20'd0, 16'd0}, 1'b0, '0});
        vectors.push_back('{'{20'd0, 20'hFFFFF, 16'hFFFF}, 1'b0, '0});
        vectors.push_back('{'{20'd519888, 20'd415148, SKIP16}, 1'b0, '0});
        vectors.push_back('{'{SKIP20, 20'd415148, 16'd30000}, 1'b0, '0});
        vectors.push_back('{'{20'd519888, SKIP20, 16'd30000}, 1'b0, '0});
        vectors.push_back('{'{20'd519888, 20'd415148, 16'h7FFF}, 1'b0, '0});
        vectors.push_back('{'{20'd519888, 20'd415148, 16'd1}, 1'b0, '0});
        vectors.push_back('{'{20'd519888, 20'd415148, 16'h8001}, 1'b0, '0});
        vectors.push_back('{'{20'h7FFFF, 20'h7FFFF, 16'h7FFF}, 1'b0, '0});
        vectors.push_back('{'{20'h80001, 20'h80001, 16'h8001}, 1'b0, '0});
        foreach (vectors[i])
        begin
            vec = vectors[i];
            if (vec.known)
                send_item(vec.raw, vec.want);
            else
                send(vec.raw);
        end
        drain();

        // extreme calibration: all ones, then all sign bits
        write_reg(REG_TEMP_CALIB, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_CALIB_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_CALIB_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_CALIB_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_HUM_CALIB, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_UNMAPPED_LO, 64'h0);
        write_reg(REG_UNMAPPED_HI, 64'h1);
        repeat (30) send(rand_sample());
        drain();
        write_reg(REG_TEMP_CALIB, 64'h8000_8000_8000);
        write_reg(REG_PRESS_CALIB_LOW, 64'h8000_8000_8000_8000);
        write_reg(REG_PRESS_CALIB_HIGH, 64'h8000_8000_8000_8000);
        write_reg(REG_PRESS_CALIB_LAST, 64'h8000);
        write_reg(REG_HUM_CALIB, 64'h8080_0800_8080_0080);
        repeat (30) send(rand_sample());
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 70 : 0;
            recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 14 : 0;
            load_typical();
            if (phase == 1)
                write_reg(REG_HUMIDITY_ENABLED, 64'd0);
            repeat (100) send(rand_sample());
            drain();
            write_reg(REG_TEMP_CALIB, {$urandom, $urandom});
            write_reg(REG_PRESS_CALIB_LOW, {$urandom, $urandom});
            write_reg(REG_PRESS_CALIB_HIGH, {$urandom, $urandom});
            write_reg(REG_PRESS_CALIB_LAST, {$urandom, $urandom});
            write_reg(REG_HUM_CALIB, {$urandom, $urandom});
            write_reg(REG_HUMIDITY_ENABLED, 64'($urandom_range(1)));
            repeat (40) send(rand_sample());
            drain();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/bsc_pkg.sv
rtl/bsc_div.sv
rtl/barometric_sensor_compensation.sv
tb/testbench.sv
